[hw/rtl/frame_free_list_allocator_assert.svh]
// Assertion macros shared by the allocator modules.
`ifndef FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset
`define FFLA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ffla assertion failed");
// Condition never holds at a clock edge outside reset
`define FFLA_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ffla forbidden condition seen");
`else
`define FFLA_ASSERT(lbl, clk, rstn, prop)
`define FFLA_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[hw/rtl/ffla_pkg.sv]
package ffla_pkg;

  // Field widths
  localparam int FRAME_W = 10;
  localparam int HIGH_W  = 11;
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 2;
  // Wide enough for any frame count in the supported range
  localparam int FC_W    = 17;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2
  } ffla_action_e;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW      = 2'd0,
    REG_HIGH     = 2'd1,
    REG_BOUNDARY = 2'd2
  } ffla_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_INIT
  } ffla_state_e;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [FRAME_W-1:0] freed_frame;
  } ffla_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] given_frame;
    logic               granted;
  } ffla_out_t;

  // Controller to datapath
  typedef struct packed {
    logic alloc_rd;    // read link of head, alloc pending
    logic alloc_pop;   // pop head from read link
    logic free_push;   // push freed frame
    logic init_start;  // link low frame, start walk
    logic init_step;   // link one frame of the walk
    logic out_load;    // capture result
    logic out_grant;   // result is a granted alloc
  } ffla_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic grant_ok;    // head above boundary
    logic init_more;   // walk has frames left
  } ffla_sts_t;

endpackage

[hw/rtl/ffla_ram.sv]
module ffla_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ffla_ctrl.sv]
`include "frame_free_list_allocator_assert.svh"

module ffla_ctrl import ffla_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ACT_W-1:0] action_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  ffla_sts_t        sts_i,
  output ffla_cmd_t        cmd_o
);

  ffla_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        accept;

  // Result slot is free when empty or draining this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_ALLOC: begin
              if (sts_i.grant_ok) begin
                state_d = ST_ALLOC;
              end
            end
            ACT_INIT: state_d = ST_INIT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_INIT: begin
        if (!sts_i.init_more && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_ALLOC: begin
              if (sts_i.grant_ok) begin
                cmd_o.alloc_rd = 1'b1;
              end else begin
                cmd_o.out_load = 1'b1;
              end
            end
            ACT_FREE: begin
              cmd_o.free_push = 1'b1;
              cmd_o.out_load  = 1'b1;
            end
            ACT_INIT: cmd_o.init_start = 1'b1;
            default:  cmd_o.out_load   = 1'b1;
          endcase
        end
      end
      ST_ALLOC: begin
        if (out_free) begin
          cmd_o.alloc_pop = 1'b1;
          cmd_o.out_load  = 1'b1;
          cmd_o.out_grant = 1'b1;
        end
      end
      ST_INIT: begin
        if (sts_i.init_more) begin
          cmd_o.init_step = 1'b1;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `FFLA_ASSERT(a_rd_enters_alloc, clk_i, rst_ni, cmd_o.alloc_rd |=> state_q == ST_ALLOC)
  `FFLA_NEVER(a_no_result_overwrite, clk_i, rst_ni, cmd_o.out_load && out_valid_q && out_stall_i)
  `FFLA_ASSERT(a_one_list_cmd, clk_i, rst_ni, $onehot0({cmd_o.alloc_rd, cmd_o.alloc_pop, cmd_o.free_push, cmd_o.init_start, cmd_o.init_step}))

endmodule

[hw/rtl/ffla_dp.sv]
`include "frame_free_list_allocator_assert.svh"

module ffla_dp import ffla_pkg::*; #(
  parameter int FRAME_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [HIGH_W-1:0]  cfg_data_i,
  input  logic [FRAME_W-1:0] freed_frame_i,
  input  ffla_cmd_t          cmd_i,
  output ffla_sts_t          sts_o,
  output ffla_out_t          out_item_o
);

  localparam int AW = $clog2(FRAME_COUNT);
  localparam logic [FC_W-1:0] FC = FC_W'(FRAME_COUNT);

  logic [FRAME_W-1:0] low_q, low_d;
  logic [HIGH_W-1:0]  high_q, high_d;
  logic [FRAME_W-1:0] bnd_q, bnd_d;
  logic [FRAME_W-1:0] head_q, head_d;
  logic [HIGH_W-1:0]  walk_q, walk_d;
  logic               pop_ok_q, pop_ok_d;
  ffla_out_t          out_q, out_d;

  logic               cfg_we;
  logic [HIGH_W-1:0]  top;
  logic               head_in, freed_in, low_in;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [FRAME_W-1:0] ram_wdata;
  logic [FRAME_W-1:0] ram_rdata;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    bnd_d  = bnd_q;
    if (cfg_we) begin
      case (cfg_index_i)
        REG_LOW:      low_d  = cfg_data_i[FRAME_W-1:0];
        REG_HIGH:     high_d = cfg_data_i;
        REG_BOUNDARY: bnd_d  = cfg_data_i[FRAME_W-1:0];
        default:      low_d  = low_q;
      endcase
    end
  end

  // Clamp the init range to the table, flag frames that fall outside it
  assign top      = ({{(FC_W-HIGH_W){1'b0}}, high_q} > FC) ? HIGH_W'(FC) : high_q;
  assign head_in  = {{(FC_W-FRAME_W){1'b0}}, head_q} < FC;
  assign freed_in = {{(FC_W-FRAME_W){1'b0}}, freed_frame_i} < FC;
  assign low_in   = {{(FC_W-FRAME_W){1'b0}}, low_q} < FC;

  assign sts_o.grant_ok  = head_q > bnd_q;
  assign sts_o.init_more = walk_q < top;

  // Link table port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(walk_q);
    ram_wdata = walk_q[FRAME_W-1:0] - FRAME_W'(1);
    if (cmd_i.free_push) begin
      ram_we    = freed_in;
      ram_waddr = AW'(freed_frame_i);
      ram_wdata = head_q;
    end else if (cmd_i.init_start) begin
      ram_we    = low_in;
      ram_waddr = AW'(low_q);
      ram_wdata = '0;
    end else if (cmd_i.init_step) begin
      ram_we    = 1'b1;
    end
  end

  assign ram_re = cmd_i.alloc_rd && head_in;

  ffla_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(FRAME_COUNT)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(AW'(head_q)),
    .rdata_o(ram_rdata)
  );

  // Head, walk counter and pending read flag
  always_comb begin
    head_d   = head_q;
    walk_d   = walk_q;
    pop_ok_d = pop_ok_q;
    if (cmd_i.alloc_rd) begin
      pop_ok_d = head_in;
    end
    if (cmd_i.alloc_pop) begin
      head_d = pop_ok_q ? ram_rdata : '0;
    end
    if (cmd_i.free_push) begin
      head_d = freed_frame_i;
    end
    if (cmd_i.init_start) begin
      head_d = low_q;
      walk_d = {1'b0, low_q} + HIGH_W'(1);
    end
    if (cmd_i.init_step) begin
      head_d = walk_q[FRAME_W-1:0];
      walk_d = walk_q + HIGH_W'(1);
    end
  end

  // Result register: head on a granted alloc, zero otherwise
  always_comb begin
    out_d = out_q;
    if (cmd_i.out_load) begin
      out_d.given_frame = cmd_i.out_grant ? head_q : '0;
      out_d.granted     = cmd_i.out_grant;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= HIGH_W'(1024);
      bnd_q    <= '0;
      head_q   <= '0;
      walk_q   <= '0;
      pop_ok_q <= 1'b0;
    end else begin
      low_q    <= low_d;
      high_q   <= high_d;
      bnd_q    <= bnd_d;
      head_q   <= head_d;
      walk_q   <= walk_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_item_o = out_q;

  `FFLA_NEVER(a_step_in_range, clk_i, rst_ni, cmd_i.init_step && !sts_o.init_more)

endmodule

[hw/rtl/frame_free_list_allocator.sv]
// Channel  Dir  Handshake             Payload
// in       in   in_valid_i/in_stall_o  in_item_i   (action, freed_frame)
// out      out  out_valid_o/out_stall_i out_item_o (given_frame, granted)
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Free, refused alloc and unused action load the result when accepted. Granted
// alloc reads the link RAM first (registered read), then pops the head and loads
// the result once the slot is free. Init: one link write per cycle, then the result.
// Reset sets head to 0 and the registers to low 0, high 1024, boundary 0; the
// link RAM is not cleared. One item is worked at a time; a stalled result holds
// off the next item until it is taken.
module frame_free_list_allocator import ffla_pkg::*; #(
  parameter int FRAME_COUNT = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffla_in_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ffla_out_t         out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [HIGH_W-1:0] cfg_data_i
);

  ffla_cmd_t cmd;
  ffla_sts_t sts;

  ffla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (in_item_i.action),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffla_dp #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .freed_frame_i(in_item_i.freed_frame),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_item_o   (out_item_o)
  );

endmodule

[verif/tb_top.sv]
module tb_top;
  import ffla_pkg::*;

  localparam int FRAMES      = 1024;
  // Longest list rebuild plus slack; covers any walk still running
  localparam int WALK_CYCLES = FRAMES + 64;
  localparam int CYCLE_LIMIT = 600000;

  // Codes the package leaves out: the spare action and the spare register slot
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [IDX_W-1:0] REG_SPARE  = 2'd3;

  // Tracks the free list and the replies owed by the block
  class frame_list_board;
    logic [FRAME_W-1:0] head_frame;
    logic [FRAME_W-1:0] low_frame;
    logic [HIGH_W-1:0]  high_frame;
    logic [FRAME_W-1:0] bound_frame;
    logic [FRAME_W-1:0] link [FRAMES];
    logic [FRAME_W-1:0] held[$];
    ffla_out_t          replies_due[$];
    int mismatches, items, results, grants, refusals, frees, rebuilds, settings;

    function new();
      head_frame  = '0;
      low_frame   = '0;
      high_frame  = 11'd1024;
      bound_frame = '0;
    endfunction

    function void load_reg(logic [IDX_W-1:0] idx, logic [HIGH_W-1:0] data);
      case (idx)
        REG_LOW:      low_frame   = data[FRAME_W-1:0];
        REG_HIGH:     high_frame  = data;
        REG_BOUNDARY: bound_frame = data[FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted item to the list and queue the reply it owes
    function void take_request(ffla_in_t it);
      ffla_out_t want;
      int top;
      want  = '0;
      items++;
      case (it.action)
        ACT_ALLOC: begin
          if (head_frame > bound_frame) begin
            want.given_frame = head_frame;
            want.granted     = 1'b1;
            held.push_back(head_frame);
            head_frame = link[head_frame];
            grants++;
          end else begin
            refusals++;
          end
        end
        ACT_FREE: begin
          link[it.freed_frame] = head_frame;
          head_frame = it.freed_frame;
          frees++;
        end
        ACT_INIT: begin
          // Walk up from the low frame, each frame linked to the one below
          top = (high_frame > FRAMES) ? FRAMES : int'(high_frame);
          link[low_frame] = '0;
          head_frame = low_frame;
          for (int f = int'(low_frame) + 1; f < top; f++) begin
            link[f]    = FRAME_W'(f - 1);
            head_frame = FRAME_W'(f);
          end
          held.delete();
          rebuilds++;
        end
        default: ;
      endcase
      replies_due.push_back(want);
    endfunction

    function void match_reply(ffla_out_t got);
      ffla_out_t want;
      results++;
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none due: given_frame %0d granted %0b",
                 $time, got.given_frame, got.granted);
        return;
      end
      want = replies_due.pop_front();
      if (got.given_frame !== want.given_frame) begin
        mismatches++;
        $display("%0t: given_frame expected %0d actual %0d",
                 $time, want.given_frame, got.given_frame);
      end
      if (got.granted !== want.granted) begin
        mismatches++;
        $display("%0t: granted expected %0b actual %0b",
                 $time, want.granted, got.granted);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  ffla_in_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  ffla_out_t         out_item_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [HIGH_W-1:0] cfg_data_i  = '0;

  frame_list_board board = new();
  bit calm = 1'b0;
  int cycles = 0;

  frame_free_list_allocator #(
    .FRAME_COUNT(FRAMES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check replies; stall the reply channel about a quarter of the time
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.match_reply(out_item_o);
    end
    out_stall_i <= !calm && ($urandom_range(99) < 25);
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one item, hold it until taken, then maybe idle
  task automatic send_item(logic [ACT_W-1:0] action, logic [FRAME_W-1:0] frame);
    ffla_in_t it;
    it.action      = action;
    it.freed_frame = frame;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.take_request(it);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Wait until every reply is in and any list walk has finished
  task automatic settle();
    while (board.replies_due.size() != 0) @(posedge clk_i);
    repeat (WALK_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [IDX_W-1:0] idx, logic [HIGH_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    board.load_reg(idx, data);
  endtask

  // Reprogram all registers once the block has gone quiet
  task automatic program_regs(logic [HIGH_W-1:0] lo, logic [HIGH_W-1:0] hi,
                              logic [HIGH_W-1:0] bd, bit poke_spare);
    in_valid_i <= 1'b0;
    settle();
    put_reg(REG_LOW, lo);
    put_reg(REG_HIGH, hi);
    put_reg(REG_BOUNDARY, bd);
    if (poke_spare) put_reg(REG_SPARE, 11'h7FF);
    cfg_valid_i <= 1'b0;
    board.settings++;
  endtask

  // Mostly small windows, now and then the whole table or an empty one
  task automatic random_regs();
    logic [HIGH_W-1:0] lo, hi, bd;
    int mode;
    mode = $urandom_range(9);
    lo   = HIGH_W'($urandom_range(FRAMES - 1));
    hi   = lo + HIGH_W'($urandom_range(48));
    if (mode == 0) begin
      lo = '0;
      hi = $urandom_range(1) ? 11'd1024 : 11'h7FF;
    end else if (mode == 1) begin
      hi = HIGH_W'($urandom_range(lo));
    end
    if (lo == 0 || mode == 2) bd = HIGH_W'($urandom_range(FRAMES - 1));
    else bd = HIGH_W'($urandom_range(lo - 1));
    // Upper data bit is dropped for the 10-bit registers
    lo[HIGH_W-1] = 1'($urandom_range(1));
    bd[HIGH_W-1] = 1'($urandom_range(1));
    program_regs(lo, hi, bd, 1'b0);
  endtask

  // Mostly allocs and frees of frames handed out earlier, some noise
  function automatic ffla_in_t pick_item();
    ffla_in_t it;
    int unsigned r, k;
    r = $urandom_range(99);
    it.freed_frame = FRAME_W'($urandom_range(FRAMES - 1));
    if (r < 50) begin
      it.action = ACT_ALLOC;
    end else if (r < 88) begin
      it.action = ACT_FREE;
      if (board.held.size() != 0 && $urandom_range(9) < 7) begin
        k = $urandom_range(board.held.size() - 1);
        it.freed_frame = board.held[k];
        board.held.delete(k);
      end
    end else if (r < 94) begin
      it.action = ACT_INIT;
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  initial begin
    ffla_in_t it;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: alloc on an empty head, spare action, push and pop
    send_item(ACT_ALLOC, '0);
    send_item(ACT_UNUSED, 10'd1023);
    send_item(ACT_FREE, 10'd1023);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_FREE, '0);
    send_item(ACT_ALLOC, '0);
    // Full table walk, then pop and push at the top
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_FREE, 10'd1023);
    send_item(ACT_ALLOC, '0);

    // High past the table end saturates; one frame above the boundary
    program_regs(11'd1023, 11'h7FF, 11'd1022, 1'b0);
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_ALLOC, '0);

    // Empty window links only the low frame
    program_regs(11'd7, 11'd7, 11'd6, 1'b0);
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_ALLOC, '0);

    // High below low behaves the same
    program_regs(11'd3, 11'd0, 11'd0, 1'b0);
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_ALLOC, '0);

    // Boundary at the top refuses everything; spare register slot ignored
    program_regs(11'd10, 11'd20, 11'h7FF, 1'b1);
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_FREE, 10'd1023);
    send_item(ACT_ALLOC, '0);

    // Random phases: rebuild the list, then a mix of traffic
    for (int p = 0; p < 10; p++) begin
      random_regs();
      calm = (p == 4 || p == 5);
      send_item(ACT_INIT, FRAME_W'($urandom_range(FRAMES - 1)));
      for (int n = 0; n < 49; n++) begin
        it = pick_item();
        send_item(it.action, it.freed_frame);
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    settle();
    $display("covered %0d items over %0d register settings: %0d grants, %0d refusals",
             board.items, board.settings, board.grants, board.refusals);
    $display("  %0d frees, %0d list rebuilds, %0d replies checked",
             board.frees, board.rebuilds, board.results);
    if (board.mismatches == 0 && board.replies_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d replies missing",
               board.mismatches, board.replies_due.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
